/* rtl/nns_pkg.sv */
// ----------------------------------------------------------------------------
// nns_pkg : shared types and constants of the nearest-neighbour scaler
// Sizes, codes, the queue word and the clamped size bundle.
// ----------------------------------------------------------------------------
package nns_pkg;

   // frame store geometry
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // field widths
   localparam int COORD_W  = 8;
   localparam int SIZE_W   = 9;
   localparam int PIXEL_W  = 32;
   localparam int STATUS_W = 2;
   localparam int PROD_W   = COORD_W + SIZE_W;

   // divider: two quotient bits per cycle
   localparam int DIV_CYCLES = COORD_W / 2;
   localparam int CNT_W      = $clog2(DIV_CYCLES);

   // command queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_WR_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RD_RANGE = 2'd2;

   // register indexes
   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   // class of a queued command
   typedef enum logic [1:0] {
      KIND_WR     = 2'd0,
      KIND_WR_ERR = 2'd1,
      KIND_RD     = 2'd2,
      KIND_RD_ERR = 2'd3
   } kind_type;

   // clamped sizes in use
   typedef struct packed {
      logic [SIZE_W-1:0] src_width;
      logic [SIZE_W-1:0] src_height;
      logic [SIZE_W-1:0] dst_width;
      logic [SIZE_W-1:0] dst_height;
   } cfg_type;

   // one queued command word
   typedef struct packed {
      kind_type           kind;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
      logic [PIXEL_W-1:0] pixel;
      logic [PROD_W-1:0]  num_x;
      logic [PROD_W-1:0]  num_y;
   } entry_type;

endpackage

/* rtl/nearest_neighbor_image_scaler.sv */
// Reads pass through the two dividers (2 quotient bits a cycle), then the
// address and store states; writes skip the dividers and out-of-range
// commands go straight to the result. Commands execute one at a time; the
// queue takes new ones while the sequencer is busy, until it is full.
// Reset: clears the sequencer and queue and sets all sizes to 1; the frame
// store is not cleared. Results are strobed for one cycle and cannot be held.
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler : nearest-neighbour RGBA frame scaler
// Stores source pixels and returns the source pixel nearest to a
// destination coordinate under the configured scale.
// ----------------------------------------------------------------------------
module nearest_neighbor_image_scaler (
   input  logic                          clock,
   input  logic                          reset,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [nns_pkg::SIZE_W-1:0]    csr_data,
   // commands
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [nns_pkg::COORD_W-1:0]   req_coord_x,
   input  logic [nns_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [nns_pkg::PIXEL_W-1:0]   req_pixel_in,
   // results
   output logic                          rsp_valid,
   output logic [nns_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   output logic [nns_pkg::STATUS_W-1:0]  rsp_status
);

   nns_pkg::entry_type front_entry;
   nns_pkg::entry_type q_data;
   nns_pkg::cfg_type   cfg;
   logic               q_full, q_empty, q_pop;

   assign busy = q_full;

   nns_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (nns_pkg::csr_index_type'(csr_index)),
      .csr_data     (csr_data),
      .req_command  (req_command),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_pixel_in (req_pixel_in),
      .entry        (front_entry),
      .cfg          (cfg)
   );

   nns_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (start),
      .push_data (front_entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   nns_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .q_empty       (q_empty),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_status    (rsp_status)
   );

endmodule

/* rtl/nns_front.sv */
// ----------------------------------------------------------------------------
// nns_front : register file and command classifier
// Holds the size registers, range-checks each command and forms the
// scaled numerators for reads before the word enters the queue.
// ----------------------------------------------------------------------------
module nns_front (
   input  logic                          clock,
   input  logic                          reset,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  nns_pkg::csr_index_type        csr_index,
   input  logic [nns_pkg::SIZE_W-1:0]    csr_data,
   // command in
   input  logic                          req_command,
   input  logic [nns_pkg::COORD_W-1:0]   req_coord_x,
   input  logic [nns_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [nns_pkg::PIXEL_W-1:0]   req_pixel_in,
   // classified word out
   output nns_pkg::entry_type            entry,
   output nns_pkg::cfg_type              cfg
);

   logic [nns_pkg::SIZE_W-1:0] src_width_ff,  src_width_in;
   logic [nns_pkg::SIZE_W-1:0] src_height_ff, src_height_in;
   logic [nns_pkg::SIZE_W-1:0] dst_width_ff,  dst_width_in;
   logic [nns_pkg::SIZE_W-1:0] dst_height_ff, dst_height_in;
   logic                       x_out, y_out;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      dst_width_in  = dst_width_ff;
      dst_height_in = dst_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            nns_pkg::CSR_SRC_WIDTH:  src_width_in  = csr_data;
            nns_pkg::CSR_SRC_HEIGHT: src_height_in = csr_data;
            nns_pkg::CSR_DST_WIDTH:  dst_width_in  = csr_data;
            nns_pkg::CSR_DST_HEIGHT: dst_height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= nns_pkg::SIZE_W'(1);
         src_height_ff <= nns_pkg::SIZE_W'(1);
         dst_width_ff  <= nns_pkg::SIZE_W'(1);
         dst_height_ff <= nns_pkg::SIZE_W'(1);
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
         dst_width_ff  <= dst_width_in;
         dst_height_ff <= dst_height_in;
      end
   end

   // sizes in use: zero acts as one, source capped at the store size
   always_comb begin
      if (src_width_ff == '0)
         cfg.src_width = nns_pkg::SIZE_W'(1);
      else if (int'(src_width_ff) > nns_pkg::MAX_WIDTH)
         cfg.src_width = nns_pkg::SIZE_W'(nns_pkg::MAX_WIDTH);
      else
         cfg.src_width = src_width_ff;

      if (src_height_ff == '0)
         cfg.src_height = nns_pkg::SIZE_W'(1);
      else if (int'(src_height_ff) > nns_pkg::MAX_HEIGHT)
         cfg.src_height = nns_pkg::SIZE_W'(nns_pkg::MAX_HEIGHT);
      else
         cfg.src_height = src_height_ff;

      cfg.dst_width  = (dst_width_ff  == '0) ? nns_pkg::SIZE_W'(1) : dst_width_ff;
      cfg.dst_height = (dst_height_ff == '0) ? nns_pkg::SIZE_W'(1) : dst_height_ff;
   end

   // range check against source sizes for writes, destination for reads
   always_comb begin
      if (req_command == nns_pkg::CMD_WRITE) begin
         x_out = nns_pkg::SIZE_W'(req_coord_x) >= cfg.src_width;
         y_out = nns_pkg::SIZE_W'(req_coord_y) >= cfg.src_height;
      end else begin
         x_out = nns_pkg::SIZE_W'(req_coord_x) >= cfg.dst_width;
         y_out = nns_pkg::SIZE_W'(req_coord_y) >= cfg.dst_height;
      end
   end

   // classify and form the numerators x*sw, y*sh
   always_comb begin
      if (req_command == nns_pkg::CMD_WRITE)
         entry.kind = (x_out || y_out) ? nns_pkg::KIND_WR_ERR : nns_pkg::KIND_WR;
      else
         entry.kind = (x_out || y_out) ? nns_pkg::KIND_RD_ERR : nns_pkg::KIND_RD;
      entry.coord_x = req_coord_x;
      entry.coord_y = req_coord_y;
      entry.pixel   = req_pixel_in;
      entry.num_x   = nns_pkg::PROD_W'(req_coord_x) * nns_pkg::PROD_W'(cfg.src_width);
      entry.num_y   = nns_pkg::PROD_W'(req_coord_y) * nns_pkg::PROD_W'(cfg.src_height);
   end

endmodule

/* rtl/nns_queue.sv */
// ----------------------------------------------------------------------------
// nns_queue : short command queue
// Decouples the classifier from the execution side; two words deep.
// ----------------------------------------------------------------------------
module nns_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nns_pkg::entry_type push_data,
   input  logic               pop,
   output nns_pkg::entry_type pop_data,
   output logic               full,
   output logic               empty
);

   nns_pkg::entry_type          slot_ff [nns_pkg::QUEUE_DEPTH];
   logic [nns_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [nns_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [nns_pkg::QPTR_W:0]    count_ff,  count_in;
   logic                        do_push, do_pop;

   assign full     = (count_ff == (nns_pkg::QPTR_W+1)'(nns_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push)
         wr_ptr_in = (int'(wr_ptr_ff) == nns_pkg::QUEUE_DEPTH - 1) ? '0 :
                     wr_ptr_ff + nns_pkg::QPTR_W'(1);
      if (do_pop)
         rd_ptr_in = (int'(rd_ptr_ff) == nns_pkg::QUEUE_DEPTH - 1) ? '0 :
                     rd_ptr_ff + nns_pkg::QPTR_W'(1);
      count_in = count_ff + (nns_pkg::QPTR_W+1)'(do_push) - (nns_pkg::QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* rtl/nns_back.sv */
// ----------------------------------------------------------------------------
// nns_back : command execution
// Runs the two coordinate dividers (reads), forms the store address and
// accesses the frame store when in range; one result word per command.
// ----------------------------------------------------------------------------
module nns_back (
   input  logic                           clock,
   input  logic                           reset,
   input  nns_pkg::cfg_type               cfg,
   // queue side
   input  logic                           q_empty,
   input  nns_pkg::entry_type             q_data,
   output logic                           q_pop,
   // result
   output logic                           rsp_valid,
   output logic [nns_pkg::PIXEL_W-1:0]    rsp_pixel_out,
   output logic [nns_pkg::STATUS_W-1:0]   rsp_status
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_ADDR = 5'b00100,
      ST_MEM  = 5'b01000,
      ST_RESP = 5'b10000
   } state_type;

   typedef struct packed {
      logic [nns_pkg::SIZE_W-1:0]  rem;
      logic [nns_pkg::COORD_W-1:0] shreg;
   } div_type;

   // one restoring step: shift a numerator bit in, subtract if it fits
   function automatic div_type div_step(input div_type cur,
                                        input logic [nns_pkg::SIZE_W-1:0] den);
      logic [nns_pkg::SIZE_W:0] trial;
      logic                     fits;
      div_type                  nxt;
      trial     = {cur.rem, cur.shreg[nns_pkg::COORD_W-1]};
      fits      = trial >= {1'b0, den};
      nxt.rem   = fits ? nns_pkg::SIZE_W'(trial - {1'b0, den}) : nns_pkg::SIZE_W'(trial);
      nxt.shreg = {cur.shreg[nns_pkg::COORD_W-2:0], fits};
      return nxt;
   endfunction

   state_type                    state_ff, state_in;
   nns_pkg::entry_type           ent_ff, ent_in;
   div_type                      divx_ff, divx_in;
   div_type                      divy_ff, divy_in;
   logic [nns_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [nns_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [nns_pkg::PIXEL_W-1:0]  rdata_ff;
   logic [nns_pkg::PIXEL_W-1:0]  store [nns_pkg::STORE_DEPTH];
   logic [nns_pkg::COORD_W-1:0]  col, row;

   // column and row: quotients for reads, coordinates for writes
   assign col = (ent_ff.kind == nns_pkg::KIND_RD) ? divx_ff.shreg : ent_ff.coord_x;
   assign row = (ent_ff.kind == nns_pkg::KIND_RD) ? divy_ff.shreg : ent_ff.coord_y;

   // sequencer
   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      divx_in  = divx_ff;
      divy_in  = divy_ff;
      cnt_in   = cnt_ff;
      addr_in  = addr_ff;
      q_pop    = 1'b0;
      unique case (state_ff) inside
         ST_IDLE, ST_RESP: begin
            state_in = ST_IDLE;
            if (!q_empty) begin
               q_pop         = 1'b1;
               ent_in        = q_data;
               cnt_in        = '0;
               divx_in.rem   = q_data.num_x[nns_pkg::PROD_W-1:nns_pkg::COORD_W];
               divx_in.shreg = q_data.num_x[nns_pkg::COORD_W-1:0];
               divy_in.rem   = q_data.num_y[nns_pkg::PROD_W-1:nns_pkg::COORD_W];
               divy_in.shreg = q_data.num_y[nns_pkg::COORD_W-1:0];
               case (q_data.kind)
                  nns_pkg::KIND_RD: state_in = ST_DIV;
                  nns_pkg::KIND_WR: state_in = ST_ADDR;
                  default:          state_in = ST_RESP;
               endcase
            end
         end
         ST_DIV: begin
            divx_in = div_step(div_step(divx_ff, cfg.dst_width), cfg.dst_width);
            divy_in = div_step(div_step(divy_ff, cfg.dst_height), cfg.dst_height);
            cnt_in  = cnt_ff + nns_pkg::CNT_W'(1);
            if (int'(cnt_ff) == nns_pkg::DIV_CYCLES - 1)
               state_in = ST_ADDR;
         end
         ST_ADDR: begin
            addr_in  = nns_pkg::ADDR_W'(nns_pkg::PROD_W'(col) +
                       nns_pkg::PROD_W'(row) * nns_pkg::PROD_W'(cfg.src_width));
            state_in = ST_MEM;
         end
         ST_MEM: begin
            state_in = ST_RESP;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      divx_ff <= divx_in;
      divy_ff <= divy_in;
      cnt_ff  <= cnt_in;
      addr_ff <= addr_in;
   end

   // frame store: one port, registered read
   always_ff @(posedge clock) begin
      if (state_ff == ST_MEM) begin
         if (ent_ff.kind == nns_pkg::KIND_WR)
            store[addr_ff] <= ent_ff.pixel;
         rdata_ff <= store[addr_ff];
      end
   end

   // result word
   always_comb begin
      rsp_valid     = (state_ff == ST_RESP);
      rsp_pixel_out = (ent_ff.kind == nns_pkg::KIND_RD) ? rdata_ff : '0;
      case (ent_ff.kind)
         nns_pkg::KIND_WR_ERR: rsp_status = nns_pkg::STATUS_WR_RANGE;
         nns_pkg::KIND_RD_ERR: rsp_status = nns_pkg::STATUS_RD_RANGE;
         default:              rsp_status = nns_pkg::STATUS_OK;
      endcase
   end

endmodule
